[hdl/umidi_pkg.sv]
// shared types and constants of the usb midi event packet encoder
`timescale 1ns / 1ps
`default_nettype none

package umidi_pkg;

    // number of virtual cables with sysex state
    localparam int CABLE_COUNT = 16;
    localparam int CABLE_IDX_W = (CABLE_COUNT > 1) ? $clog2(CABLE_COUNT) : 1;

    // code index numbers
    localparam logic [3:0] CIN_SYSCOM_TWO   = 4'h2;
    localparam logic [3:0] CIN_SYSCOM_THREE = 4'h3;
    localparam logic [3:0] CIN_SYSEX_GO     = 4'h4;
    localparam logic [3:0] CIN_END_ONE      = 4'h5;
    localparam logic [3:0] CIN_END_TWO      = 4'h6;
    localparam logic [3:0] CIN_END_THREE    = 4'h7;
    localparam logic [3:0] CIN_REALTIME     = 4'hF;

    // status bytes
    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_MTC_QUARTER = 8'hF1;
    localparam logic [7:0] ST_SONG_POS    = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
    localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;
    localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [7:0] ST_REALTIME_LO = 8'hF8;
    localparam logic [7:0] ST_CHANNEL_LO  = 8'h80;
    localparam logic [7:0] ST_CHANNEL_HI  = 8'hEF;

    // operation codes
    localparam logic OP_SHORT = 1'b0;
    localparam logic OP_SYSEX = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [3:0] cable_number;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic [1:0] message_length;
    } item_t;

    typedef struct packed {
        logic        active;
        logic [1:0]  count;
        logic [23:0] bytes;
    } sx_entry_t;

    typedef struct packed {
        logic        emit;
        logic        write;
        sx_entry_t   entry;
        logic [31:0] word;
    } enc_result_t;

    function automatic logic [31:0] pack_word(input logic [3:0] cable, input logic [3:0] cin,
                                              input logic [7:0] b1, input logic [7:0] b2,
                                              input logic [7:0] b3);
        pack_word = {b3, b2, b1, cable, cin};
    endfunction

endpackage

`default_nettype wire

[hdl/umidi_encode.sv]
// packet encoder: one item plus its cable's sysex entry to a packet and new entry
`timescale 1ns / 1ps
`default_nettype none

module umidi_encode (
    input  wire umidi_pkg::item_t       item,
    input  wire umidi_pkg::sx_entry_t   entry,
    input  wire                         cable_ok,
    output umidi_pkg::enc_result_t      res
);
    import umidi_pkg::*;

    logic [7:0]  st;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [1:0]  cnt;
    logic [1:0]  cnt_inc;
    logic [23:0] data;

    always_comb begin
        st      = item.first_byte;
        b2      = (item.message_length >= 2'd2) ? item.second_byte : 8'h00;
        b3      = (item.message_length == 2'd3) ? item.third_byte : 8'h00;
        cnt     = (entry.count > 2'd2) ? 2'd2 : entry.count;
        cnt_inc = cnt + 2'd1;
        case (cnt)
            2'd0:    data = {entry.bytes[23:8], st};
            2'd1:    data = {entry.bytes[23:16], st, entry.bytes[7:0]};
            default: data = {st, entry.bytes[15:0]};
        endcase

        res.emit  = 1'b0;
        res.write = 1'b0;
        res.entry = entry;
        res.word  = 32'h0;

        if (item.operation == OP_SHORT) begin
            if (item.message_length == 2'd0 || st == ST_SYSEX_START || st == ST_SYSEX_END) begin
                res.emit = 1'b0;
            end else if (st >= ST_REALTIME_LO) begin
                res.emit = 1'b1;
                res.word = pack_word(item.cable_number, CIN_REALTIME, st, 8'h00, 8'h00);
            end else if (st == ST_TUNE_REQ) begin
                res.emit = 1'b1;
                res.word = pack_word(item.cable_number, CIN_END_ONE, st, b2, b3);
            end else if (st == ST_MTC_QUARTER || st == ST_SONG_SEL) begin
                res.emit = 1'b1;
                res.word = pack_word(item.cable_number, CIN_SYSCOM_TWO, st, b2, b3);
            end else if (st == ST_SONG_POS) begin
                res.emit = 1'b1;
                res.word = pack_word(item.cable_number, CIN_SYSCOM_THREE, st, b2, b3);
            end else if (st >= ST_CHANNEL_LO && st <= ST_CHANNEL_HI) begin
                res.emit = 1'b1;
                res.word = pack_word(item.cable_number, st[7:4], st, b2, b3);
            end
        end else if (!cable_ok) begin
            res.emit = 1'b0;
        end else if ((st >= ST_MTC_QUARTER && st <= ST_TUNE_REQ) || st >= ST_REALTIME_LO) begin
            // real-time and system common inside the stream are dropped
            res.emit = 1'b0;
        end else if (st == ST_SYSEX_START) begin
            res.write        = 1'b1;
            res.entry.active = 1'b1;
            res.entry.count  = 2'd1;
            res.entry.bytes  = {16'h0000, ST_SYSEX_START};
        end else if (entry.active) begin
            res.write       = 1'b1;
            res.entry.bytes = data;
            if (st == ST_SYSEX_END) begin
                res.emit         = 1'b1;
                res.entry.active = 1'b0;
                res.entry.count  = 2'd0;
                case (cnt_inc)
                    2'd1: res.word = pack_word(item.cable_number, CIN_END_ONE,
                                               data[7:0], 8'h00, 8'h00);
                    2'd2: res.word = pack_word(item.cable_number, CIN_END_TWO,
                                               data[7:0], data[15:8], 8'h00);
                    default: res.word = pack_word(item.cable_number, CIN_END_THREE,
                                                  data[7:0], data[15:8], data[23:16]);
                endcase
            end else if (cnt_inc == 2'd3) begin
                res.emit        = 1'b1;
                res.entry.count = 2'd0;
                res.word        = pack_word(item.cable_number, CIN_SYSEX_GO,
                                            data[7:0], data[15:8], data[23:16]);
            end else begin
                res.entry.count = cnt_inc;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/usb_midi_packetizer_top.sv]
// top level of the usb midi event packet encoder
//
// usage:
//   input stream: one word per short midi message or per sysex byte
//     s_tuser[0] selects the kind (0 short message, 1 sysex stream byte)
//     s_tdata carries cable, status or stream byte, two data bytes, length
//   output stream: one 32-bit usb-midi event packet per word on m_tdata
//     an input word gives zero or one packet; words that give none vanish
//   path: an accepted input word waits in the input register until the packet
//     register is free, and its packet is then held in the packet register
//   throughput: one word per cycle sustained while m_tready stays high; the
//     per-cable sysex entry is read and rewritten in the same cycle, so words
//     for the same cable may follow each other without gaps
//   reset: aresetn low clears the valid flags of both pipeline registers and
//     every cable's sysex flag and count at the next edge; the block is ready right after
//   stall: while m_tready is low a packet holds on m_tdata; one more input
//     word is still taken into the input register before s_tready drops
`timescale 1ns / 1ps
`default_nettype none

module usb_midi_packetizer_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // s_tdata: cable_number[3:0], first_byte[11:4], second_byte[19:12],
    //          third_byte[27:20], message_length[29:28], zero fill[31:30]
    input  wire  [31:0] s_tdata,
    // s_tuser: operation[0]
    input  wire  [0:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // m_tdata: packet_word[31:0]
    output logic [31:0] m_tdata
);
    import umidi_pkg::*;

    // input register
    logic        item_valid_reg;
    item_t       item_reg;

    // per-cable sysex state
    logic        active_reg [CABLE_COUNT];
    logic [1:0]  count_reg  [CABLE_COUNT];
    logic [23:0] bytes_reg  [CABLE_COUNT];

    // packet register
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    logic                   out_free;
    logic                   advance;
    logic                   cable_ok;
    logic [CABLE_IDX_W-1:0] cable_idx;
    sx_entry_t              cur_entry;
    enc_result_t            res;

    // a packet slot frees when empty or taken this cycle
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = item_valid_reg && out_free;
    assign s_tready = !item_valid_reg || out_free;

    assign cable_ok  = ({1'b0, item_reg.cable_number} < 5'(CABLE_COUNT));
    assign cable_idx = item_reg.cable_number[CABLE_IDX_W-1:0];

    always_comb begin
        cur_entry = '0;
        if (cable_ok) begin
            cur_entry.active = active_reg[cable_idx];
            cur_entry.count  = count_reg[cable_idx];
            cur_entry.bytes  = bytes_reg[cable_idx];
        end
    end

    umidi_encode u_encode (
        .item     (item_reg),
        .entry    (cur_entry),
        .cable_ok (cable_ok),
        .res      (res)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.operation      <= s_tuser[0];
            item_reg.cable_number   <= s_tdata[3:0];
            item_reg.first_byte     <= s_tdata[11:4];
            item_reg.second_byte    <= s_tdata[19:12];
            item_reg.third_byte     <= s_tdata[27:20];
            item_reg.message_length <= s_tdata[29:28];
        end
    end

    // sysex state update, only when the word moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CABLE_COUNT; i++) begin
                active_reg[i] <= 1'b0;
                count_reg[i]  <= 2'd0;
            end
        end else if (advance && res.write) begin
            active_reg[cable_idx] <= res.entry.active;
            count_reg[cable_idx]  <= res.entry.count;
        end
    end

    // gathered bytes above the count are never shown, so no reset
    always_ff @(posedge aclk) begin
        if (advance && res.write) begin
            bytes_reg[cable_idx] <= res.entry.bytes;
        end
    end

    // packet register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && res.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.emit) begin
            out_data_reg <= res.word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    // a word that makes a packet shows it on the next cycle
    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res.emit) |=> (m_tvalid && m_tdata == $past(res.word)))
        else $error("packet lost after encode");

    // a taken packet with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !(advance && res.emit)) |=> !m_tvalid)
        else $error("packet repeated");

    // the gathered byte count never reaches a full packet in storage
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid_reg |-> (cur_entry.count != 2'd3))
        else $error("sysex count out of range");

    // the input register holds while the output is blocked
    a_hold_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid_reg && !out_free) |=> (item_valid_reg && $stable(item_reg)))
        else $error("input word dropped under stall");
`endif

endmodule

`default_nettype wire

[sim/usb_midi_packetizer_checker.sv]
// packet predictor and scoreboard for the usb midi event packet encoder
`timescale 1ns / 1ps

module usb_midi_packetizer_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [31:0] s_tdata,
    input  wire  [0:0]  s_tuser,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [31:0] m_tdata,
    output int          mismatch_count,
    output int          packets_pending,
    output int          packets_checked
);
    import umidi_pkg::*;

    // per-cable sysex gathering state
    logic        sysex_open [CABLE_COUNT];
    logic [1:0]  held_count [CABLE_COUNT];
    logic [23:0] held_bytes [CABLE_COUNT];

    logic [31:0] expected_packets [$];

    initial begin
        mismatch_count  = 0;
        packets_pending = 0;
        packets_checked = 0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // short message path: no state touched
    task automatic encode_short(input item_t it, output logic emit, output logic [31:0] word);
        logic [7:0] st;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [3:0] cin;
        st   = it.first_byte;
        b2   = (it.message_length >= 2) ? it.second_byte : 8'h00;
        b3   = (it.message_length == 3) ? it.third_byte : 8'h00;
        emit = 1'b0;
        word = '0;
        cin  = '0;
        if (it.message_length == 0 || st == ST_SYSEX_START || st == ST_SYSEX_END) begin
            emit = 1'b0;
        end else if (st >= ST_REALTIME_LO) begin
            emit = 1'b1;
            word = {8'h00, 8'h00, st, it.cable_number, CIN_REALTIME};
        end else if (st >= ST_MTC_QUARTER) begin
            emit = 1'b1;
            case (st)
                ST_TUNE_REQ:                 cin = CIN_END_ONE;
                ST_MTC_QUARTER, ST_SONG_SEL: cin = CIN_SYSCOM_TWO;
                ST_SONG_POS:                 cin = CIN_SYSCOM_THREE;
                default:                     emit = 1'b0;
            endcase
            word = {b3, b2, st, it.cable_number, cin};
        end else if (st >= ST_CHANNEL_LO) begin
            emit = 1'b1;
            word = {b3, b2, st, it.cable_number, st[7:4]};
        end
    endtask

    // sysex stream path: gathers bytes per cable
    task automatic encode_sysex(input item_t it, output logic emit, output logic [31:0] word);
        int          c;
        int          n;
        logic [7:0]  b;
        logic [23:0] data;
        logic [3:0]  cin;
        c    = int'(it.cable_number);
        b    = it.first_byte;
        emit = 1'b0;
        word = '0;
        if (c >= CABLE_COUNT) begin
            emit = 1'b0;
        end else if ((b >= ST_MTC_QUARTER && b <= ST_TUNE_REQ) || b >= ST_REALTIME_LO) begin
            emit = 1'b0;
        end else if (b == ST_SYSEX_START) begin
            held_bytes[c] = {16'h0000, ST_SYSEX_START};
            held_count[c] = 2'd1;
            sysex_open[c] = 1'b1;
        end else if (sysex_open[c]) begin
            n = int'(held_count[c]);
            if (n > 2) n = 2;
            data = held_bytes[c];
            data[8*n +: 8] = b;
            held_bytes[c] = data;
            n++;
            if (b == ST_SYSEX_END) begin
                cin  = (n == 1) ? CIN_END_ONE : (n == 2) ? CIN_END_TWO : CIN_END_THREE;
                emit = 1'b1;
                word = {(n >= 3) ? data[23:16] : 8'h00, (n >= 2) ? data[15:8] : 8'h00,
                        data[7:0], it.cable_number, cin};
                held_count[c] = 2'd0;
                sysex_open[c] = 1'b0;
            end else if (n >= 3) begin
                emit = 1'b1;
                word = {data, it.cable_number, CIN_SYSEX_GO};
                held_count[c] = 2'd0;
            end else begin
                held_count[c] = n[1:0];
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        item_t       it;
        logic        emit;
        logic [31:0] word;
        logic [31:0] want;
        if (!aresetn) begin
            for (int i = 0; i < CABLE_COUNT; i++) begin
                sysex_open[i] = 1'b0;
                held_count[i] = 2'd0;
                held_bytes[i] = 24'h000000;
            end
            expected_packets.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_packets.size() == 0) begin
                    report_mismatch($sformatf("unexpected packet %08h", m_tdata));
                end else begin
                    want = expected_packets.pop_front();
                    packets_checked++;
                    if (m_tdata !== want) begin
                        report_mismatch($sformatf(
                            "packet %08h, expected %08h (cin %h/%h cable %0d/%0d)",
                            m_tdata, want, m_tdata[3:0], want[3:0], m_tdata[7:4], want[7:4]));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                it.operation      = s_tuser[0];
                it.cable_number   = s_tdata[3:0];
                it.first_byte     = s_tdata[11:4];
                it.second_byte    = s_tdata[19:12];
                it.third_byte     = s_tdata[27:20];
                it.message_length = s_tdata[29:28];
                if (it.operation == OP_SHORT) encode_short(it, emit, word);
                else encode_sysex(it, emit, word);
                if (emit) expected_packets.push_back(word);
            end
        end
        packets_pending = expected_packets.size();
    end

endmodule

[sim/usb_midi_packetizer_top_test.sv]
// testbench top for the usb midi event packet encoder: stimulus, stalls and verdict
`timescale 1ns / 1ps

module usb_midi_packetizer_top_test;
    import umidi_pkg::*;

    localparam realtime     CLK_PERIOD      = 12.0;
    localparam int          RANDOM_WORDS    = 1500;
    localparam int          HOLD_CYCLES     = 80;
    localparam int          DRAIN_LIMIT     = 5000;
    localparam int unsigned WATCHDOG_CYCLES = 200_000;

    // status bytes the package has no name for
    localparam logic [7:0] ST_UNDEFINED = 8'hF4;   // undefined system common
    localparam logic [7:0] ST_RT_START  = 8'hFA;   // real-time start, ignored inside sysex

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    int mismatch_count;
    int packets_pending;
    int packets_checked;

    // idle control shared by the sender and receiver processes
    bit send_calm;
    bit recv_calm;
    bit long_hold;

    int short_words;
    int sysex_words;

    usb_midi_packetizer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    usb_midi_packetizer_checker packet_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .packets_pending (packets_pending),
        .packets_checked (packets_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("watchdog expired at %0t", $time);
        $display("Some tests failed");
        $finish;
    end

    // receiver: random back-pressure, a calm stretch, and one long hold-off
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                // hold-off counted here so the sender keeps pushing meanwhile
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                long_hold = 1'b0;
            end else if (recv_calm) begin
                m_tready = 1'b1;
            end else begin
                m_tready = ($urandom_range(99) >= 37);
            end
        end
    end

    // offer one word, called at a falling edge; returns at the falling edge
    // after the word was taken, with valid still high
    task automatic send_word(input item_t it);
        while (!send_calm && $urandom_range(99) < 37) begin
            // idle cycle with junk on the bus, must be ignored
            s_tvalid = 1'b0;
            s_tdata  = $urandom();
            s_tuser  = 1'($urandom_range(1));
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = it.operation;
        s_tdata  = {2'b00, it.message_length, it.third_byte, it.second_byte,
                    it.first_byte, it.cable_number};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (it.operation == OP_SHORT) short_words++;
        else sysex_words++;
    endtask

    task automatic send_short(input logic [3:0] cable, input logic [7:0] st,
                              input logic [7:0] b2, input logic [7:0] b3,
                              input logic [1:0] len);
        item_t it;
        it.operation      = OP_SHORT;
        it.cable_number   = cable;
        it.first_byte     = st;
        it.second_byte    = b2;
        it.third_byte     = b3;
        it.message_length = len;
        send_word(it);
    endtask

    task automatic send_sysex(input logic [3:0] cable, input logic [7:0] b);
        item_t it;
        it.operation      = OP_SYSEX;
        it.cable_number   = cable;
        it.first_byte     = b;
        // unused fields still toggle
        it.second_byte    = 8'($urandom_range(255));
        it.third_byte     = 8'($urandom_range(255));
        it.message_length = 2'($urandom_range(3));
        send_word(it);
    endtask

    // random sysex byte generator state, per cable
    bit seq_open [16];
    int seq_left [16];

    initial begin : stimulus
        int         cable;
        int         roll;
        int         drain_cycles;
        logic [7:0] st;
        logic [7:0] b;

        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        send_calm   = 1'b0;
        recv_calm   = 1'b0;
        long_hold   = 1'b0;
        short_words = 0;
        sysex_words = 0;
        for (int i = 0; i < 16; i++) begin
            seq_open[i] = 1'b0;
            seq_left[i] = 0;
        end

        // synchronous reset held low across rising edges of the clock
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // ---- directed: short messages ----
        send_short(4'd0,  ST_REALTIME_LO, 8'hAA, 8'h55, 2'd1);  // real-time clock
        send_short(4'd15, 8'hFF,          8'hFF, 8'hFF, 2'd3);  // real-time drops data bytes
        send_short(4'd5,  ST_TUNE_REQ,    8'h12, 8'h34, 2'd1);  // tune request, single byte
        send_short(4'd1,  ST_MTC_QUARTER, 8'h7F, 8'h00, 2'd2);  // two-byte system common
        send_short(4'd2,  ST_SONG_POS,    8'h00, 8'h7F, 2'd3);  // three-byte system common
        send_short(4'd3,  ST_UNDEFINED,   8'h01, 8'h02, 2'd2);  // undefined, no packet
        send_short(4'd4,  ST_SYSEX_START, 8'h01, 8'h02, 2'd3);  // sysex start on short path
        send_short(4'd4,  8'h7F,          8'h01, 8'h02, 2'd3);  // data byte as status
        send_short(4'd6,  8'h90,          8'h3C, 8'h7F, 2'd0);  // zero length
        send_short(4'd7,  ST_CHANNEL_LO,  8'hFF, 8'hFF, 2'd3);  // lowest channel status
        send_short(4'd8,  ST_CHANNEL_HI,  8'h01, 8'h02, 2'd3);  // highest channel status
        send_short(4'd9,  8'hC5,          8'h20, 8'h99, 2'd1);  // bytes beyond length zeroed

        // ---- directed: sysex streams ----
        send_sysex(4'd3,  8'h55);                // stray byte with no sysex open
        send_sysex(4'd3,  ST_SYSEX_END);         // lone end byte
        send_sysex(4'd15, ST_SYSEX_START);
        send_sysex(4'd15, ST_CHANNEL_LO);        // status byte gathered as data
        send_sysex(4'd15, ST_RT_START);          // real-time inside sysex, ignored
        send_sysex(4'd15, 8'h00);                // completes a cin 4 packet
        send_sysex(4'd15, ST_SYSEX_END);         // end with one byte
        send_sysex(4'd2,  ST_SYSEX_START);
        send_sysex(4'd2,  8'h11);
        send_sysex(4'd2,  ST_SYSEX_START);       // repeated start restarts gathering
        send_sysex(4'd2,  ST_SYSEX_END);         // end with two bytes
        send_sysex(4'd0,  ST_SYSEX_START);
        send_sysex(4'd0,  8'h7F);
        send_sysex(4'd0,  ST_SYSEX_END);         // end with three bytes

        // ---- random: mostly well-formed sysex runs interleaved with short messages ----
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // one long hold-off early on to fill the pipeline
            if (n == 300) long_hold = 1'b1;
            // calm stretch on both sides
            recv_calm = (n >= 600 && n < 900);
            send_calm = recv_calm || long_hold;

            roll = $urandom_range(99);
            if (roll < 35) begin
                st = ($urandom_range(3) != 0) ? 8'($urandom_range(8'h80, 8'hFF))
                                              : 8'($urandom_range(255));
                send_short(4'($urandom_range(15)), st, 8'($urandom_range(255)),
                           8'($urandom_range(255)), 2'($urandom_range(3)));
            end else begin
                // a few busy cables so that runs interleave
                cable = ($urandom_range(9) < 7) ? $urandom_range(3) : $urandom_range(15);
                roll  = $urandom_range(99);
                if (!seq_open[cable]) begin
                    if (roll < 88) begin
                        b = ST_SYSEX_START;
                        seq_open[cable] = 1'b1;
                        seq_left[cable] = $urandom_range(8);
                    end else begin
                        b = 8'($urandom_range(255));   // noise outside a run
                    end
                end else if (seq_left[cable] == 0) begin
                    if (roll < 90) begin
                        b = ST_SYSEX_END;
                        seq_open[cable] = 1'b0;
                    end else begin
                        // broken run: restart it
                        b = ST_SYSEX_START;
                        seq_left[cable] = $urandom_range(5);
                    end
                end else begin
                    seq_left[cable]--;
                    if (roll < 78)      b = 8'($urandom_range(8'h7F));
                    else if (roll < 90) b = 8'($urandom_range(ST_CHANNEL_LO, ST_CHANNEL_HI));
                    else                b = 8'($urandom_range(ST_MTC_QUARTER, 8'hFF));
                end
                send_sysex(4'(cable), b);
            end
        end
        s_tvalid  = 1'b0;
        send_calm = 1'b0;
        recv_calm = 1'b0;

        // drain what the block still owes, then allow for its pipeline depth
        drain_cycles = 0;
        while (packets_pending != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(negedge aclk);
            drain_cycles++;
        end
        if (packets_pending != 0) begin
            $display("drain timeout with %0d packets outstanding", packets_pending);
            $display("Some tests failed");
        end else begin
            repeat (4) @(negedge aclk);
            $display("covered %0d short messages and %0d sysex stream bytes on 16 cables",
                     short_words, sysex_words);
            $display("%0d packets compared, %0d mismatches, %0d left unmatched",
                     packets_checked, mismatch_count, packets_pending);
            if (mismatch_count == 0 && packets_pending == 0) begin
                $display("All tests passed");
            end else begin
                $display("Some tests failed");
            end
        end
        $finish;
    end

endmodule
